// ===== rtl/gas_pkg.sv =====
`timescale 1ns / 1ps

package gas_pkg;

   // field widths of the transfers
   localparam int unsigned NODE_W   = 6;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 7;

   // default sizing
   localparam int unsigned MAX_NODES_DEF  = 64;
   localparam int unsigned MAX_DEGREE_DEF = 16;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

   // operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_LIST = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DEG,
      S_SCAN
   } state_type;

endpackage

// ===== rtl/gas_ram.sv =====
`timescale 1ns / 1ps

module gas_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/graph_adjacency_store_unit.sv =====
`timescale 1ns / 1ps

// Directed adjacency store: every node owns MAX_DEGREE neighbour slots, filled
// in insertion order, plus a degree count.
//
// Request: raise start with req_op/req_node/req_dest; the transfer happens at
// a clock edge with start high and busy low. Add edge (op 0) gives one result:
// ok, edge already exists, list full or node out of range. List (op 1) gives
// one result per stored neighbour, or one "no neighbours" or out-of-range result.
// Results appear on rsp_* for exactly one cycle, flagged by rsp_strobe, with
// rsp_last on the final one; the receiver has no way to stall them.
//
// Timing: a node out of range answers on the next cycle and leaves busy low.
// Otherwise the degree is read first, then the slot memory is walked one
// slot per cycle up to the degree, an add stopping early on a duplicate;
// the single read port of the slot memory sets that pace.
//
// csr_node_count is always ready; write it only while idle.
// Reset: node_count returns to 64 and the degree memory is swept to zero, one
// node per cycle, over all MAX_NODES entries with busy high. Slot contents
// are only read below a node's degree and need no clearing.
module graph_adjacency_store_unit #(
   parameter int unsigned MAX_NODES  = gas_pkg::MAX_NODES_DEF,
   parameter int unsigned MAX_DEGREE = gas_pkg::MAX_DEGREE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [gas_pkg::NODE_W-1:0]      req_node,
   input  logic [gas_pkg::NODE_W-1:0]      req_dest,
   // result
   output logic                            rsp_strobe,
   output logic [gas_pkg::STATUS_W-1:0]    rsp_status,
   output logic [gas_pkg::NODE_W-1:0]      rsp_neighbour,
   output logic                            rsp_last,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gas_pkg::COUNT_W-1:0]     csr_node_count
);

   localparam int unsigned NODE_AW = $clog2(MAX_NODES);
   localparam int unsigned SLOTS   = MAX_NODES * MAX_DEGREE;
   localparam int unsigned SLOT_AW = $clog2(SLOTS);
   localparam int unsigned DEG_W   = $clog2(MAX_DEGREE + 1);
   localparam int unsigned NODE_XW = (NODE_AW > gas_pkg::NODE_W) ? NODE_AW : gas_pkg::NODE_W;

   localparam logic [NODE_AW-1:0] CLR_LAST = NODE_AW'(MAX_NODES - 1);
   localparam logic [DEG_W-1:0]   DEG_FULL = DEG_W'(MAX_DEGREE);

   // registers
   gas_pkg::state_type               state_ff, state_in;
   logic [gas_pkg::COUNT_W-1:0]      node_count_ff;
   logic                             op_ff, op_in;
   logic [NODE_AW-1:0]               node_ff, node_in;
   logic [gas_pkg::NODE_W-1:0]       dest_ff, dest_in;
   logic [SLOT_AW-1:0]               base_ff, base_in;
   logic [DEG_W-1:0]                 deg_ff, deg_in;
   logic [DEG_W-1:0]                 k_ff, k_in;
   logic [NODE_AW-1:0]               clr_ff, clr_in;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   logic [gas_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [gas_pkg::NODE_W-1:0]       rsp_neighbour_ff, rsp_neighbour_in;
   logic                             rsp_last_ff, rsp_last_in;

   // memory ports
   logic                             deg_wr_en, deg_rd_en;
   logic [NODE_AW-1:0]               deg_wr_addr, deg_rd_addr;
   logic [DEG_W-1:0]                 deg_wr_data, deg_rd_data;
   logic                             slot_wr_en, slot_rd_en;
   logic [SLOT_AW-1:0]               slot_wr_addr, slot_rd_addr;
   logic [gas_pkg::NODE_W-1:0]       slot_wr_data, slot_rd_data;

   // request decode
   logic [NODE_XW-1:0]               req_node_wide;
   logic [NODE_AW-1:0]               req_node_addr;
   logic                             node_ok, dest_ok, req_ok;
   // scan decode
   logic [DEG_W-1:0]                 k_nxt;
   logic                             last_slot, dup_hit;

   gas_ram #(
      .WIDTH (DEG_W),
      .DEPTH (MAX_NODES)
   ) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_wr_en),
      .wr_addr (deg_wr_addr),
      .wr_data (deg_wr_data),
      .rd_en   (deg_rd_en),
      .rd_addr (deg_rd_addr),
      .rd_data (deg_rd_data)
   );

   gas_ram #(
      .WIDTH (gas_pkg::NODE_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // a node is in range below both node_count and MAX_NODES
   assign req_node_wide = NODE_XW'(req_node);
   assign req_node_addr = req_node_wide[NODE_AW-1:0];
   assign node_ok = ({1'b0, req_node} < node_count_ff) && (32'(req_node) < MAX_NODES);
   assign dest_ok = ({1'b0, req_dest} < node_count_ff) && (32'(req_dest) < MAX_NODES);
   assign req_ok  = node_ok && (req_op == gas_pkg::OP_LIST || dest_ok);

   // slot data arriving in the scan belongs to index k_ff
   assign k_nxt     = DEG_W'(k_ff + 1'b1);
   assign last_slot = (k_nxt == deg_ff);
   assign dup_hit   = (slot_rd_data == dest_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gas_pkg::S_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = gas_pkg::S_IDLE;
            end
         end
         gas_pkg::S_IDLE: begin
            if (start && req_ok) begin
               state_in = gas_pkg::S_DEG;
            end
         end
         gas_pkg::S_DEG: begin
            if (deg_rd_data == '0) begin
               state_in = gas_pkg::S_IDLE;
            end else begin
               state_in = gas_pkg::S_SCAN;
            end
         end
         gas_pkg::S_SCAN: begin
            if (last_slot || (op_ff == gas_pkg::OP_ADD && dup_hit)) begin
               state_in = gas_pkg::S_IDLE;
            end
         end
         default: state_in = gas_pkg::S_IDLE;
      endcase
   end

   // datapath, memory control and results
   always_comb begin
      op_in            = op_ff;
      node_in          = node_ff;
      dest_in          = dest_ff;
      base_in          = base_ff;
      deg_in           = deg_ff;
      k_in             = k_ff;
      clr_in           = clr_ff;
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_neighbour_in = rsp_neighbour_ff;
      rsp_last_in      = rsp_last_ff;
      deg_wr_en        = 1'b0;
      deg_wr_addr      = node_ff;
      deg_wr_data      = '0;
      deg_rd_en        = 1'b0;
      deg_rd_addr      = req_node_addr;
      slot_wr_en       = 1'b0;
      slot_wr_addr     = SLOT_AW'(base_ff + SLOT_AW'(deg_ff));
      slot_wr_data     = dest_ff;
      slot_rd_en       = 1'b0;
      slot_rd_addr     = base_ff;

      unique case (state_ff)
         gas_pkg::S_CLEAR: begin
            // sweep degree counts to zero
            deg_wr_en   = 1'b1;
            deg_wr_addr = clr_ff;
            clr_in      = NODE_AW'(clr_ff + 1'b1);
         end
         gas_pkg::S_IDLE: begin
            if (start) begin
               op_in   = req_op;
               node_in = req_node_addr;
               dest_in = req_dest;
               base_in = SLOT_AW'(req_node_addr * MAX_DEGREE);
               if (req_ok) begin
                  deg_rd_en = 1'b1;
               end else begin
                  rsp_strobe_in    = 1'b1;
                  rsp_status_in    = gas_pkg::ST_RANGE;
                  rsp_neighbour_in = '0;
                  rsp_last_in      = 1'b1;
               end
            end
         end
         gas_pkg::S_DEG: begin
            deg_in = deg_rd_data;
            k_in   = '0;
            if (deg_rd_data == '0) begin
               rsp_strobe_in    = 1'b1;
               rsp_neighbour_in = '0;
               rsp_last_in      = 1'b1;
               if (op_ff == gas_pkg::OP_LIST) begin
                  rsp_status_in = gas_pkg::ST_EMPTY;
               end else begin
                  // empty list: append into slot zero
                  rsp_status_in = gas_pkg::ST_OK;
                  slot_wr_en    = 1'b1;
                  slot_wr_addr  = base_ff;
                  deg_wr_en     = 1'b1;
                  deg_wr_data   = DEG_W'(1);
               end
            end else begin
               slot_rd_en = 1'b1;
            end
         end
         gas_pkg::S_SCAN: begin
            k_in = k_nxt;
            if (!last_slot) begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = SLOT_AW'(base_ff + SLOT_AW'(k_nxt));
            end
            if (op_ff == gas_pkg::OP_LIST) begin
               rsp_strobe_in    = 1'b1;
               rsp_status_in    = gas_pkg::ST_OK;
               rsp_neighbour_in = slot_rd_data;
               rsp_last_in      = last_slot;
            end else if (dup_hit) begin
               rsp_strobe_in    = 1'b1;
               rsp_status_in    = gas_pkg::ST_EXISTS;
               rsp_neighbour_in = '0;
               rsp_last_in      = 1'b1;
            end else if (last_slot) begin
               rsp_strobe_in    = 1'b1;
               rsp_neighbour_in = '0;
               rsp_last_in      = 1'b1;
               if (deg_ff == DEG_FULL) begin
                  rsp_status_in = gas_pkg::ST_FULL;
               end else begin
                  rsp_status_in = gas_pkg::ST_OK;
                  slot_wr_en    = 1'b1;
                  deg_wr_en     = 1'b1;
                  deg_wr_data   = DEG_W'(deg_ff + 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gas_pkg::S_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         node_count_ff <= gas_pkg::NODE_COUNT_RST;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      node_ff          <= node_in;
      dest_ff          <= dest_in;
      base_ff          <= base_in;
      deg_ff           <= deg_in;
      k_ff             <= k_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_neighbour_ff <= rsp_neighbour_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign busy          = (state_ff != gas_pkg::S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_neighbour = rsp_neighbour_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== rtl/gas_checker.sv =====
`timescale 1ns / 1ps

module gas_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_op,
   input logic [gas_pkg::NODE_W-1:0]   req_node,
   input logic [gas_pkg::NODE_W-1:0]   req_dest,
   input logic                         rsp_strobe,
   input logic [gas_pkg::STATUS_W-1:0] rsp_status,
   input logic [gas_pkg::NODE_W-1:0]   rsp_neighbour,
   input logic                         rsp_last,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic [gas_pkg::COUNT_W-1:0]  csr_node_count
);

   // reset starts the clearing sweep
   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // an accepted transfer is either answered at once or holds the block busy
   a_accept_follow: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("request accepted but neither answered nor busy");

   // every status other than ok ends the item
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != gas_pkg::ST_OK) |-> rsp_last)
      else $error("error status without last");

   // a neighbour number only travels with an ok status
   a_neighbour_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_neighbour != '0) |-> (rsp_status == gas_pkg::ST_OK))
      else $error("neighbour set on non-ok result");

   // more results of a listing follow without a gap
   a_list_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a neighbour listing");

endmodule

bind graph_adjacency_store_unit gas_checker u_gas_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   // Self-checking bench for the adjacency store. Every accepted request is
   // mirrored in a shadow copy of the degree counts and neighbour slots, which
   // yields the answers the block must give; a monitor pops them in order and
   // compares each strobed result field by field.

   localparam int unsigned NODES    = gas_pkg::MAX_NODES_DEF;
   localparam int unsigned DEGREE   = gas_pkg::MAX_DEGREE_DEF;
   localparam int unsigned NODE_W   = gas_pkg::NODE_W;
   localparam int unsigned STATUS_W = gas_pkg::STATUS_W;
   localparam int unsigned COUNT_W  = gas_pkg::COUNT_W;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   neighbour;
      logic                last;
   } answer_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic                req_op         = gas_pkg::OP_ADD;
   logic [NODE_W-1:0]   req_node       = '0;
   logic [NODE_W-1:0]   req_dest       = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [NODE_W-1:0]   rsp_neighbour;
   logic                rsp_last;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_node_count = gas_pkg::NODE_COUNT_RST;

   // shadow of the graph as the block should hold it
   int unsigned         shadow_degree [NODES];
   logic [NODE_W-1:0]   shadow_slot [NODES][DEGREE];
   logic [COUNT_W-1:0]  shadow_node_count = gas_pkg::NODE_COUNT_RST;

   answer_type          awaited_results[$];
   int unsigned         mismatch_count = 0;
   int unsigned         idle_pct = 0;

   graph_adjacency_store_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_node       (req_node),
      .req_dest       (req_dest),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_neighbour  (rsp_neighbour),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_node_count (csr_node_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A node number counts only below both the programmed count and the
   // table size, so counts above the table size behave as the table size.
   function automatic bit node_ok(logic [NODE_W-1:0] n);
      return (n < shadow_node_count) && (n < NODES);
   endfunction

   // Apply one request to the shadow graph and queue the answers it earns.
   function automatic void apply_graph_op(logic op, logic [NODE_W-1:0] node,
                                          logic [NODE_W-1:0] dest);
      int unsigned deg;
      bit          dup;
      if (!node_ok(node) || (op == gas_pkg::OP_ADD && !node_ok(dest))) begin
         awaited_results.push_back('{status: gas_pkg::ST_RANGE, neighbour: '0,
                                     last: 1'b1});
         return;
      end
      deg = shadow_degree[node];
      if (op == gas_pkg::OP_ADD) begin
         dup = 1'b0;
         for (int unsigned k = 0; k < deg; k++)
            if (shadow_slot[node][k] == dest) dup = 1'b1;
         // the duplicate check wins over a full list
         if (dup) begin
            awaited_results.push_back('{status: gas_pkg::ST_EXISTS, neighbour: '0,
                                        last: 1'b1});
         end else if (deg >= DEGREE) begin
            awaited_results.push_back('{status: gas_pkg::ST_FULL, neighbour: '0,
                                        last: 1'b1});
         end else begin
            shadow_slot[node][deg] = dest;
            shadow_degree[node]    = deg + 1;
            awaited_results.push_back('{status: gas_pkg::ST_OK, neighbour: '0,
                                        last: 1'b1});
         end
      end else if (deg == 0) begin
         awaited_results.push_back('{status: gas_pkg::ST_EMPTY, neighbour: '0,
                                     last: 1'b1});
      end else begin
         for (int unsigned k = 0; k < deg; k++)
            awaited_results.push_back('{status: gas_pkg::ST_OK,
                                        neighbour: shadow_slot[node][k],
                                        last: (k + 1 == deg)});
      end
   endfunction

   // Send one request: idle for a random spell first, then hold start until
   // the transfer. Start stays high on return so that a back-to-back request
   // needs no second assignment in the same step.
   task automatic send_request(logic op, logic [NODE_W-1:0] node,
                               logic [NODE_W-1:0] dest);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_op   <= op;
      req_node <= node;
      req_dest <= dest;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_graph_op(op, node, dest);
   endtask

   // Drop start, wait for every answer, then let the block fall idle.
   task automatic settle();
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DEGREE + 4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_node_count(logic [COUNT_W-1:0] value);
      settle();
      csr_valid      <= 1'b1;
      csr_node_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid         <= 1'b0;
      shadow_node_count  = value;
   endtask

   // Fresh lists at both ends of the node range are empty.
   task automatic test_empty_lists();
      send_request(gas_pkg::OP_LIST, 6'd0, 6'd63);
      send_request(gas_pkg::OP_LIST, 6'd63, 6'd0);
   endtask

   // Plain adds, a self loop, a duplicate and a listing in insertion order.
   task automatic test_edge_add();
      send_request(gas_pkg::OP_ADD, 6'd0, 6'd63);
      send_request(gas_pkg::OP_ADD, 6'd0, 6'd0);
      send_request(gas_pkg::OP_ADD, 6'd0, 6'd63);
      send_request(gas_pkg::OP_LIST, 6'd0, 6'd21);
   endtask

   // Fill one list, overflow it, repeat an edge once full, list all slots.
   task automatic test_full_list();
      for (int unsigned d = 0; d < DEGREE; d++)
         send_request(gas_pkg::OP_ADD, 6'd5, NODE_W'(10 + d));
      send_request(gas_pkg::OP_ADD, 6'd5, 6'd40);
      send_request(gas_pkg::OP_ADD, 6'd5, 6'd10);
      send_request(gas_pkg::OP_LIST, 6'd5, 6'd42);
   endtask

   // A count of one, a zero count and a count beyond the table.
   task automatic test_node_range();
      write_node_count(7'd1);
      send_request(gas_pkg::OP_ADD, 6'd0, 6'd1);
      send_request(gas_pkg::OP_LIST, 6'd1, 6'd0);
      write_node_count(7'd0);
      send_request(gas_pkg::OP_LIST, 6'd0, 6'd0);
      write_node_count(7'd127);
      send_request(gas_pkg::OP_ADD, 6'd63, 6'd62);
      send_request(gas_pkg::OP_LIST, 6'd63, 6'd0);
   endtask

   // Mostly traffic on a few busy nodes so lists fill up, duplicates recur
   // and listings get long; the rest spreads over the whole node range.
   task automatic test_random_traffic(int unsigned count, int unsigned pct);
      logic              op;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] dest;
      idle_pct = pct;
      for (int unsigned i = 0; i < count; i++) begin
         op   = ($urandom_range(0, 99) < 55) ? gas_pkg::OP_ADD : gas_pkg::OP_LIST;
         node = ($urandom_range(0, 99) < 70) ? NODE_W'($urandom_range(0, 7))
                                             : NODE_W'($urandom_range(0, 63));
         dest = ($urandom_range(0, 99) < 50) ? NODE_W'($urandom_range(0, 19))
                                             : NODE_W'($urandom_range(0, 63));
         send_request(op, node, dest);
      end
      idle_pct = 0;
   endtask

   // Each strobed result must match the oldest outstanding answer.
   always @(posedge clock) begin
      answer_type exp_ans;
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result: status %0d neighbour %0d last %0d",
                   rsp_status, rsp_neighbour, rsp_last);
            mismatch_count++;
         end else begin
            exp_ans = awaited_results.pop_front();
            if (rsp_status !== exp_ans.status) begin
               $error("status: expected %0d, actual %0d", exp_ans.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_neighbour !== exp_ans.neighbour) begin
               $error("neighbour: expected %0d, actual %0d",
                      exp_ans.neighbour, rsp_neighbour);
               mismatch_count++;
            end
            if (rsp_last !== exp_ans.last) begin
               $error("last: expected %0d, actual %0d", exp_ans.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      for (int unsigned n = 0; n < NODES; n++) shadow_degree[n] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_lists();
      test_edge_add();
      test_full_list();
      test_node_range();

      // first the sender idles lightly, then heavily, then not at all
      write_node_count(7'd64);
      test_random_traffic(57, 17);
      write_node_count(COUNT_W'($urandom_range(8, 63)));
      test_random_traffic(57, 63);
      write_node_count(7'd100);
      test_random_traffic(57, 0);

      settle();
      if (mismatch_count == 0)
         $display("graph_adjacency_store_unit regression: pass");
      else
         $display("graph_adjacency_store_unit regression: fail");
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("graph_adjacency_store_unit regression: fail");
      $finish;
   end

endmodule
